[hw/rtl/matrix_multiply_defines.svh]
// Assertion macros for the matrix multiply block.
`ifndef MATRIX_MULTIPLY_DEFINES_SVH
`define MATRIX_MULTIPLY_DEFINES_SVH

`ifndef SYNTH

// Property checked on every clock edge outside reset.
`define MM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define MM_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define MM_ASSERT(label, prop, msg)
`define MM_ASSERT_NEVER(label, cond, msg)

`endif

`endif

[hw/rtl/mm_pkg.sv]
// Shared constants, types and helper functions of the matrix multiply block.
package mm_pkg;

  localparam int MAX_DIM   = 8;
  localparam int DIM_CAP   = (MAX_DIM < 8) ? MAX_DIM : 8;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W     = 3;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int REQ_W     = 2;
  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int VALUE_W   = 35;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_LOAD_A  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_B  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS    = 2'd2;

  // Tag that travels with one multiply-accumulate through the datapath
  typedef struct packed {
    logic             valid;
    logic             first;      // clear the accumulator
    logic             last;       // final term of the dot product
    logic             elem_last;  // final element of the product
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mm_tag_t;

  // MAC command from controller to datapath
  typedef struct packed {
    mm_tag_t           tag;
    logic [ADDR_W-1:0] a_addr;
    logic [ADDR_W-1:0] b_addr;
  } mm_cmd_t;

  // Store write command
  typedef struct packed {
    logic              a_we;
    logic              b_we;
    logic [ADDR_W-1:0] addr;
    logic [ELEM_W-1:0] data;
  } mm_wr_t;

  // Datapath status
  typedef struct packed {
    logic pipe_busy;
  } mm_stat_t;

  // Store address of an element
  function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] row,
                                                input logic [IDX_W-1:0] col);
    return ADDR_W'(32'(row) * MAX_DIM + 32'(col));
  endfunction

  // Last usable index for a dimension register: zero acts as one, large values clamp
  function automatic logic [IDX_W-1:0] dim_last(input logic [CFG_W-1:0] d);
    logic [IDX_W-1:0] r;
    if (d == '0) begin
      r = '0;
    end else if (32'(d) > DIM_CAP) begin
      r = IDX_W'(DIM_CAP - 1);
    end else begin
      r = IDX_W'(d - CFG_W'(1));
    end
    return r;
  endfunction

endpackage

[hw/rtl/mm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/mm_datapath.sv]
// Datapath: A and B stores, multiplier and accumulator, result registers.
module mm_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mm_pkg::mm_cmd_t                      cmd_i,
  input  mm_pkg::mm_wr_t                       wr_i,
  output mm_pkg::mm_stat_t                     stat_o,
  output logic                                 out_valid_o,
  output logic [mm_pkg::IDX_W-1:0]             out_row_o,
  output logic [mm_pkg::IDX_W-1:0]             out_col_o,
  output logic signed [mm_pkg::VALUE_W-1:0]    out_value_o,
  output logic                                 out_last_o
);

  logic [mm_pkg::ELEM_W-1:0]         a_rdata;
  logic [mm_pkg::ELEM_W-1:0]         b_rdata;
  mm_pkg::mm_tag_t                   tag1_q;
  mm_pkg::mm_tag_t                   tag2_q;
  logic signed [mm_pkg::PROD_W-1:0]  prod_q;
  logic signed [mm_pkg::VALUE_W-1:0] acc_q;
  logic signed [mm_pkg::VALUE_W-1:0] acc_d;
  logic                              out_valid_q;
  logic [mm_pkg::IDX_W-1:0]          out_row_q;
  logic [mm_pkg::IDX_W-1:0]          out_col_q;
  logic signed [mm_pkg::VALUE_W-1:0] out_value_q;
  logic                              out_last_q;

  // Element stores
  mm_ram #(.WIDTH(mm_pkg::ELEM_W), .DEPTH(mm_pkg::DEPTH)) u_a_store (
    .clk_i  (clk_i),
    .we_i   (wr_i.a_we),
    .waddr_i(wr_i.addr),
    .wdata_i(wr_i.data),
    .re_i   (cmd_i.tag.valid),
    .raddr_i(cmd_i.a_addr),
    .rdata_o(a_rdata)
  );

  mm_ram #(.WIDTH(mm_pkg::ELEM_W), .DEPTH(mm_pkg::DEPTH)) u_b_store (
    .clk_i  (clk_i),
    .we_i   (wr_i.b_we),
    .waddr_i(wr_i.addr),
    .wdata_i(wr_i.data),
    .re_i   (cmd_i.tag.valid),
    .raddr_i(cmd_i.b_addr),
    .rdata_o(b_rdata)
  );

  // Running sum: restart on the first term of each dot product
  assign acc_d = (tag2_q.first ? '0 : acc_q) + mm_pkg::VALUE_W'(prod_q);

  // Tag pipeline and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q      <= '0;
      tag2_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tag1_q      <= cmd_i.tag;
      tag2_q      <= tag1_q;
      out_valid_q <= tag2_q.valid && tag2_q.last;
    end
  end

  // Multiply, accumulate and result payload
  always_ff @(posedge clk_i) begin
    if (tag1_q.valid) begin
      prod_q <= $signed(a_rdata) * $signed(b_rdata);
    end
    if (tag2_q.valid) begin
      acc_q <= acc_d;
    end
    if (tag2_q.valid && tag2_q.last) begin
      out_value_q <= acc_d;
      out_row_q   <= tag2_q.row;
      out_col_q   <= tag2_q.col;
      out_last_q  <= tag2_q.elem_last;
    end
  end

  assign stat_o.pipe_busy = tag1_q.valid || tag2_q.valid || out_valid_q;

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

endmodule

[hw/rtl/mm_ctrl.sv]
// Controller: request decode, configuration registers and the MAC sequencer.
module mm_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [mm_pkg::REQ_W-1:0]         req_type_i,
  input  logic [mm_pkg::IDX_W-1:0]         row_index_i,
  input  logic [mm_pkg::IDX_W-1:0]         col_index_i,
  input  logic signed [mm_pkg::ELEM_W-1:0] element_value_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mm_pkg::CFG_W-1:0]         cfg_data_i,
  output mm_pkg::mm_cmd_t                  cmd_o,
  output mm_pkg::mm_wr_t                   wr_o,
  input  mm_pkg::mm_stat_t                 stat_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_e;

  state_e                   state_q;
  logic [mm_pkg::IDX_W-1:0] nr_last_q;
  logic [mm_pkg::IDX_W-1:0] nk_last_q;
  logic [mm_pkg::IDX_W-1:0] nc_last_q;
  logic [mm_pkg::IDX_W-1:0] i_q;
  logic [mm_pkg::IDX_W-1:0] j_q;
  logic [mm_pkg::IDX_W-1:0] t_q;
  mm_pkg::mm_cmd_t          cmd_q;
  mm_pkg::mm_wr_t           wr_q;
  mm_pkg::mm_cmd_t          issue;
  logic                     load_ok;

  // Loads outside the usable dimension are dropped
  assign load_ok = (32'(row_index_i) < mm_pkg::DIM_CAP) &&
                   (32'(col_index_i) < mm_pkg::DIM_CAP);

  // Next MAC: A[i][t] * B[t][j]
  always_comb begin
    issue.tag.valid     = 1'b1;
    issue.tag.first     = (t_q == '0);
    issue.tag.last      = (t_q == nk_last_q);
    issue.tag.elem_last = (t_q == nk_last_q) && (j_q == nc_last_q) && (i_q == nr_last_q);
    issue.tag.row       = i_q;
    issue.tag.col       = j_q;
    issue.a_addr        = mm_pkg::addr_of(i_q, t_q);
    issue.b_addr        = mm_pkg::addr_of(t_q, j_q);
  end

  // State, counters, configuration and registered commands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      nr_last_q <= '0;
      nk_last_q <= '0;
      nc_last_q <= '0;
      i_q       <= '0;
      j_q       <= '0;
      t_q       <= '0;
      cmd_q     <= '0;
      wr_q      <= '0;
    end else begin
      wr_q.a_we       <= 1'b0;
      wr_q.b_we       <= 1'b0;
      cmd_q.tag.valid <= 1'b0;

      // Configuration writes, unknown indexes ignored
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          mm_pkg::CFG_A_ROWS:    nr_last_q <= mm_pkg::dim_last(cfg_data_i);
          mm_pkg::CFG_INNER_DIM: nk_last_q <= mm_pkg::dim_last(cfg_data_i);
          mm_pkg::CFG_B_COLS:    nc_last_q <= mm_pkg::dim_last(cfg_data_i);
          default: ;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            unique case (req_type_i)
              mm_pkg::REQ_LOAD_A: begin
                wr_q.a_we <= load_ok;
                wr_q.addr <= mm_pkg::addr_of(row_index_i, col_index_i);
                wr_q.data <= element_value_i;
              end
              mm_pkg::REQ_LOAD_B: begin
                wr_q.b_we <= load_ok;
                wr_q.addr <= mm_pkg::addr_of(row_index_i, col_index_i);
                wr_q.data <= element_value_i;
              end
              mm_pkg::REQ_COMPUTE: begin
                i_q     <= '0;
                j_q     <= '0;
                t_q     <= '0;
                state_q <= ST_RUN;
              end
              default: ;
            endcase
          end
        end
        ST_RUN: begin
          cmd_q <= issue;
          if (t_q != nk_last_q) begin
            t_q <= t_q + 1'b1;
          end else begin
            t_q <= '0;
            if (j_q != nc_last_q) begin
              j_q <= j_q + 1'b1;
            end else begin
              j_q <= '0;
              i_q <= i_q + 1'b1;
            end
          end
          if (issue.tag.elem_last) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!cmd_q.tag.valid && !stat_i.pipe_busy) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign cmd_o       = cmd_q;
  assign wr_o        = wr_q;

endmodule

[hw/rtl/matrix_multiply.sv]
// Load item: busy stays low. Compute item: busy until the last result has left the datapath.
// A result strobes after its last term passes the command, store read, product and
// result registers; one shared 16x16 multiplier and one A and one B store read per cycle serve it.
// Results are strobed for one cycle each; the receiver cannot stall.
// Reset clears the sequencer and sets all dimensions to 1; stores are not cleared.
`include "matrix_multiply_defines.svh"

module matrix_multiply (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [mm_pkg::REQ_W-1:0]          req_type_i,
  input  logic [mm_pkg::IDX_W-1:0]          row_index_i,
  input  logic [mm_pkg::IDX_W-1:0]          col_index_i,
  input  logic signed [mm_pkg::ELEM_W-1:0]  element_value_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mm_pkg::CFG_W-1:0]          cfg_data_i,
  output logic                              out_valid_o,
  output logic [mm_pkg::IDX_W-1:0]          out_row_o,
  output logic [mm_pkg::IDX_W-1:0]          out_col_o,
  output logic signed [mm_pkg::VALUE_W-1:0] out_value_o,
  output logic                              out_last_o
);

  mm_pkg::mm_cmd_t  cmd;
  mm_pkg::mm_wr_t   wr;
  mm_pkg::mm_stat_t stat;

  // Sequencer
  mm_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_o         (busy),
    .req_type_i     (req_type_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .element_value_i(element_value_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_o          (cmd),
    .wr_o           (wr),
    .stat_i         (stat)
  );

  // Stores and MAC
  mm_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .wr_i       (wr),
    .stat_o     (stat),
    .out_valid_o(out_valid_o),
    .out_row_o  (out_row_o),
    .out_col_o  (out_col_o),
    .out_value_o(out_value_o),
    .out_last_o (out_last_o)
  );

  // Results only appear while a compute request is in progress
  `MM_ASSERT(a_strobe_busy, out_valid_o |-> busy, "result strobe while idle")
  // Nothing follows the final element of a product
  `MM_ASSERT(a_last_alone, (out_valid_o && out_last_o) |=> !out_valid_o, "result after last")
  // An accepted compute request always starts the sequencer
  `MM_ASSERT(a_compute_starts,
             (start && !busy && req_type_i == mm_pkg::REQ_COMPUTE) |=> busy,
             "compute request not started")
  // Store writes only come from requests taken while idle
  `MM_ASSERT_NEVER(a_write_in_run, (wr.a_we || wr.b_we) && cmd.tag.valid,
                   "store write during MAC sequence")

endmodule
